@@ rtl/mandelbrot_escape_time_defines.svh @@
// assertion macros shared by the escape-time block
`ifndef MANDELBROT_ESCAPE_TIME_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MBET_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MBET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mbet_pkg.sv @@
package mbet_pkg;

    // input word: one pixel coordinate
    typedef struct packed {
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
    } t_in_word;

    // output word: echoed pixel and escape count
    typedef struct packed {
        logic [9:0]  out_x;
        logic [9:0]  out_y;
        logic [15:0] iter_count;
    } t_out_word;

    // configuration register indexes
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_MAX_ITER = 3'd0;
    localparam t_cfg_idx CFG_START_RE = 3'd1;
    localparam t_cfg_idx CFG_START_IM = 3'd2;
    localparam t_cfg_idx CFG_STEP_RE  = 3'd3;
    localparam t_cfg_idx CFG_STEP_IM  = 3'd4;

    // register reset values
    localparam logic [15:0]        RST_MAX_ITER = 16'd1000;
    localparam logic signed [31:0] RST_START_RE = -32'sd2147483648;
    localparam logic signed [31:0] RST_START_IM = -32'sd536870912;
    localparam logic [30:0]        RST_STEP_RE  = 31'd1342177;
    localparam logic [30:0]        RST_STEP_IM  = 31'd1789570;

    // microcode address
    typedef logic [3:0] t_upc;

    // multiplier operand pair
    typedef enum logic [2:0] {
        MUL_HOLD,
        MUL_PX_SRE,
        MUL_PY_SIM,
        MUL_ZR_ZR,
        MUL_ZI_ZI,
        MUL_ZR_ZI
    } t_mul_sel;

    // branch condition
    typedef enum logic [2:0] {
        CND_NEXT,
        CND_ALWAYS,
        CND_NO_IN,
        CND_EXIT,
        CND_OUT_BUSY
    } t_cond;

    // one control word
    typedef struct packed {
        logic     in_rdy;
        t_mul_sel mul_sel;
        logic     ld_cr;
        logic     ld_ci;
        logic     clr_z;
        logic     ld_sr;
        logic     ld_si;
        logic     upd_z;
        logic     out_ld;
        t_cond    cond;
        t_upc     target;
    } t_uword;

    // status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic esc;
    } t_seq_stat;

endpackage

@@ rtl/mbet_seq.sv @@
`include "mandelbrot_escape_time_defines.svh"

module mbet_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mbet_pkg::t_seq_stat i_stat,
    output mbet_pkg::t_uword   o_uw
);
    import mbet_pkg::*;

    localparam t_upc STEP_WAIT = 4'd0;
    localparam t_upc STEP_LOOP = 4'd4;
    localparam t_upc STEP_DONE = 4'd9;
    localparam t_upc STEP_LAST = 4'd10;

    // control store
    function automatic t_uword prog_rom(input t_upc pc);
        t_uword uw;
        uw = '0;
        case (pc)
            4'd0: begin
                uw.in_rdy = 1'b1;
                uw.cond   = CND_NO_IN;
                uw.target = STEP_WAIT;
            end
            4'd1: begin
                uw.mul_sel = MUL_PX_SRE;
            end
            4'd2: begin
                uw.ld_cr   = 1'b1;
                uw.mul_sel = MUL_PY_SIM;
            end
            4'd3: begin
                uw.ld_ci = 1'b1;
                uw.clr_z = 1'b1;
            end
            4'd4: begin
                uw.mul_sel = MUL_ZR_ZR;
            end
            4'd5: begin
                uw.ld_sr   = 1'b1;
                uw.mul_sel = MUL_ZI_ZI;
            end
            4'd6: begin
                uw.ld_si   = 1'b1;
                uw.mul_sel = MUL_ZR_ZI;
            end
            4'd7: begin
                uw.cond   = CND_EXIT;
                uw.target = STEP_DONE;
            end
            4'd8: begin
                uw.upd_z  = 1'b1;
                uw.cond   = CND_ALWAYS;
                uw.target = STEP_LOOP;
            end
            4'd9: begin
                uw.out_ld = 1'b1;
                uw.cond   = CND_OUT_BUSY;
                uw.target = STEP_DONE;
            end
            default: begin
                uw.cond   = CND_ALWAYS;
                uw.target = STEP_WAIT;
            end
        endcase
        return uw;
    endfunction

    logic r_upc_valid;
    t_upc r_upc;
    t_upc n_upc;
    t_uword w_uw;
    logic w_hit;

    assign w_uw = prog_rom(r_upc);
    assign o_uw = w_uw;

    // branch decision
    always_comb begin
        case (w_uw.cond)
            CND_NEXT:     w_hit = 1'b0;
            CND_ALWAYS:   w_hit = 1'b1;
            CND_NO_IN:    w_hit = !i_stat.in_valid;
            CND_EXIT:     w_hit = i_stat.esc;
            CND_OUT_BUSY: w_hit = i_stat.out_busy;
            default:      w_hit = 1'b1;
        endcase
        n_upc = w_hit ? w_uw.target : r_upc + 4'd1;
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= STEP_WAIT;
            r_upc_valid <= 1'b0;
        end else begin
            r_upc       <= n_upc;
            r_upc_valid <= 1'b1;
        end
    end

    `MBET_ASSERT_NOW(a_upc_range, i_clk, i_rst_n, r_upc_valid, r_upc <= STEP_LAST, "step counter left the program")
    `MBET_ASSERT_NEXT(a_exit_done, i_clk, i_rst_n, w_uw.cond == CND_EXIT && i_stat.esc, r_upc == STEP_DONE, "exit did not reach the done step")
    `MBET_ASSERT_NEXT(a_loop_back, i_clk, i_rst_n, w_uw.upd_z, r_upc == STEP_LOOP, "update did not loop back")

endmodule

@@ rtl/mbet_dpath.sv @@
`include "mandelbrot_escape_time_defines.svh"

module mbet_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mbet_pkg::t_uword    i_uw,
    input  logic                i_pix_ld,
    input  mbet_pkg::t_in_word  i_pix,
    input  logic [15:0]         i_max_iter,
    input  logic signed [31:0]  i_start_re,
    input  logic signed [31:0]  i_start_im,
    input  logic [30:0]         i_step_re,
    input  logic [30:0]         i_step_im,
    output logic                o_esc,
    output mbet_pkg::t_out_word o_res
);
    import mbet_pkg::*;

    localparam logic signed [36:0] ESC_BOUND = 37'sd1073741824;
    localparam logic signed [43:0] Q_MAX     = 44'sd2147483647;
    localparam logic signed [43:0] Q_MIN     = -44'sd2147483648;

    // clamp to the Q4.28 range
    function automatic logic signed [31:0] sat_q(input logic signed [43:0] v);
        logic signed [31:0] r;
        if (v > Q_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < Q_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    t_in_word           r_pix;
    logic signed [31:0] r_cr;
    logic signed [31:0] r_ci;
    logic signed [31:0] r_zr;
    logic signed [31:0] r_zi;
    logic signed [35:0] r_sr;
    logic signed [35:0] r_si;
    logic signed [63:0] r_prod;
    logic [15:0]        r_n;

    logic signed [31:0] w_a;
    logic signed [31:0] w_b;
    logic signed [63:0] w_prod;
    logic signed [36:0] w_cross;
    logic signed [36:0] w_mag;

    // multiplier operand select
    always_comb begin
        case (i_uw.mul_sel)
            MUL_PX_SRE: begin
                w_a = 32'(r_pix.pixel_x);
                w_b = {1'b0, i_step_re};
            end
            MUL_PY_SIM: begin
                w_a = 32'(r_pix.pixel_y);
                w_b = {1'b0, i_step_im};
            end
            MUL_ZR_ZR: begin
                w_a = r_zr;
                w_b = r_zr;
            end
            MUL_ZI_ZI: begin
                w_a = r_zi;
                w_b = r_zi;
            end
            MUL_ZR_ZI: begin
                w_a = r_zr;
                w_b = r_zi;
            end
            default: begin
                w_a = r_zr;
                w_b = r_zi;
            end
        endcase
    end

    assign w_prod  = w_a * w_b;
    assign w_cross = r_prod[63:27];
    assign w_mag   = 37'(r_sr) + 37'(r_si);

    // escape test: squared magnitude over four or limit reached
    assign o_esc = (w_mag > ESC_BOUND) || (r_n >= i_max_iter);

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_pix_ld) begin
            r_pix <= i_pix;
        end
        if (i_uw.mul_sel != MUL_HOLD) begin
            r_prod <= w_prod;
        end
        if (i_uw.ld_cr) begin
            r_cr <= sat_q(44'(i_start_re) + 44'(r_prod[42:0]));
        end
        if (i_uw.ld_ci) begin
            r_ci <= sat_q(44'(i_start_im) + 44'(r_prod[42:0]));
        end
        if (i_uw.ld_sr) begin
            r_sr <= r_prod[63:28];
        end
        if (i_uw.ld_si) begin
            r_si <= r_prod[63:28];
        end
        if (i_uw.clr_z) begin
            r_zr <= '0;
            r_zi <= '0;
            r_n  <= '0;
        end else if (i_uw.upd_z) begin
            r_zr <= sat_q(44'(r_sr) - 44'(r_si) + 44'(r_cr));
            r_zi <= sat_q(44'(w_cross) + 44'(r_ci));
            r_n  <= r_n + 16'd1;
        end
    end

    assign o_res.out_x      = r_pix.pixel_x;
    assign o_res.out_y      = r_pix.pixel_y;
    assign o_res.iter_count = r_n;

    `MBET_ASSERT_NOW(a_count_limit, i_clk, i_rst_n, i_uw.upd_z, r_n < i_max_iter, "iteration past the limit")

endmodule

@@ rtl/mandelbrot_escape_time.sv @@
// channel | direction | handshake                 | word
// in      | input     | i_in_valid / o_in_stall   | pixel_x, pixel_y
// out     | output    | o_out_valid / i_out_stall | out_x, out_y, iter_count
// cfg     | input     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// a pixel's run time grows with its iteration count n: the control
// store spends five steps per iteration on the one shared 32x32 multiplier
// (three products, a test, an update), plus setup and output steps
// the next pixel is taken while the previous result waits in the output register
// synchronous active-low reset; the output stage holds its word while i_out_stall is high
`include "mandelbrot_escape_time_defines.svh"

module mandelbrot_escape_time (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mbet_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mbet_pkg::t_out_word o_out_word,
    input  logic                i_cfg_we,
    input  mbet_pkg::t_cfg_idx  i_cfg_idx,
    input  logic [31:0]         i_cfg_data
);
    import mbet_pkg::*;

    logic [15:0]        r_max_iter;
    logic signed [31:0] r_start_re;
    logic signed [31:0] r_start_im;
    logic [30:0]        r_step_re;
    logic [30:0]        r_step_im;

    logic      r_out_valid;
    t_out_word r_out_word;

    t_uword    w_uw;
    t_seq_stat w_stat;
    t_out_word w_res;
    logic      w_esc;
    logic      w_out_free;
    logic      w_out_ld;
    logic      w_in_acc;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter <= RST_MAX_ITER;
            r_start_re <= RST_START_RE;
            r_start_im <= RST_START_IM;
            r_step_re  <= RST_STEP_RE;
            r_step_im  <= RST_STEP_IM;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_ITER: r_max_iter <= i_cfg_data[15:0];
                CFG_START_RE: r_start_re <= i_cfg_data;
                CFG_START_IM: r_start_im <= i_cfg_data;
                CFG_STEP_RE:  r_step_re  <= i_cfg_data[30:0];
                CFG_STEP_IM:  r_step_im  <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    // handshake glue
    assign w_out_free      = !r_out_valid || !i_out_stall;
    assign w_out_ld        = w_uw.out_ld && w_out_free;
    assign w_in_acc        = i_in_valid && w_uw.in_rdy;
    assign o_in_stall      = !w_uw.in_rdy;
    assign w_stat.in_valid = i_in_valid;
    assign w_stat.out_busy = !w_out_free;
    assign w_stat.esc      = w_esc;

    mbet_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_uw    (w_uw)
    );

    mbet_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_uw       (w_uw),
        .i_pix_ld   (w_in_acc),
        .i_pix      (i_in_word),
        .i_max_iter (r_max_iter),
        .i_start_re (r_start_re),
        .i_start_im (r_start_im),
        .i_step_re  (r_step_re),
        .i_step_im  (r_step_im),
        .o_esc      (w_esc),
        .o_res      (w_res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_out_ld) begin
            r_out_word <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `MBET_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, w_in_acc, o_in_stall, "second word taken while busy")
    `MBET_ASSERT_NOW(a_count_cap, i_clk, i_rst_n, r_out_valid, r_out_word.iter_count <= r_max_iter, "count above the limit")

endmodule

@@ tb/mandelbrot_escape_time_tb.sv @@
`timescale 1ns / 100ps

module mandelbrot_escape_time_tb;
    import mbet_pkg::*;

    localparam int     FRAC_BITS    = 28;
    localparam longint ESCAPE_BOUND = 64'sd4 <<< FRAC_BITS;
    localparam longint Q_HI         = 64'sd2147483647;
    localparam longint Q_LO         = -64'sd2147483648;
    localparam int     ONE_Q        = 268435456;
    localparam int     IDLE_LIMIT   = 40000;
    localparam int     TAIL_CYCLES  = 100;
    localparam int     MAX_REPORTS  = 10;

    // dut ports
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in_word    in_word   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_word   out_word;
    logic        cfg_we    = 1'b0;
    t_cfg_idx    cfg_idx   = CFG_MAX_ITER;
    logic [31:0] cfg_data  = '0;

    // local copy of the register file
    logic [15:0]        cfg_max_iter = RST_MAX_ITER;
    logic signed [31:0] cfg_start_re = RST_START_RE;
    logic signed [31:0] cfg_start_im = RST_START_IM;
    logic [30:0]        cfg_step_re  = RST_STEP_RE;
    logic [30:0]        cfg_step_im  = RST_STEP_IM;

    t_out_word escape_counts_q[$];
    t_out_word want;
    int        bad_words  = 0;
    int        idle_count = 0;
    int        hold_len   = 0;
    int        stall_left = 0;
    bit        no_gaps    = 1'b0;

    mandelbrot_escape_time dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // saturate to the q4.28 range
    function automatic longint clamp_q(longint v);
        if (v > Q_HI) return Q_HI;
        if (v < Q_LO) return Q_LO;
        return v;
    endfunction

    // escape-time count of one pixel under the current registers
    function automatic t_out_word escape_count(t_in_word w);
        longint      cr, ci, zr, zi, sq_re, sq_im, cross_ri;
        int unsigned n;
        t_out_word   r;
        cr = clamp_q(longint'(cfg_start_re) + longint'(w.pixel_x) * longint'(cfg_step_re));
        ci = clamp_q(longint'(cfg_start_im) + longint'(w.pixel_y) * longint'(cfg_step_im));
        zr = 0;
        zi = 0;
        n  = 0;
        while (1) begin
            sq_re = (zr * zr) >>> FRAC_BITS;
            sq_im = (zi * zi) >>> FRAC_BITS;
            if (sq_re + sq_im > ESCAPE_BOUND || n >= cfg_max_iter) break;
            cross_ri = (zr * zi) >>> (FRAC_BITS - 1);
            zr = clamp_q(sq_re - sq_im + cr);
            zi = clamp_q(cross_ri + ci);
            n++;
        end
        r.out_x      = w.pixel_x;
        r.out_y      = w.pixel_y;
        r.iter_count = n[15:0];
        return r;
    endfunction

    // offer one word, wait for it to be taken, queue its count
    task automatic send_pixel(input logic [9:0] x, input logic [9:0] y);
        int       gap;
        t_in_word w;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        w.pixel_x = x;
        w.pixel_y = y;
        if (gap > 0) begin
            in_valid <= 1'b0;
            in_word  <= t_in_word'($urandom);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        escape_counts_q.push_back(escape_count(w));
    endtask

    // drop valid and let every pending count come back
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (escape_counts_q.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // program all registers while idle; unused upper bits carry noise
    task automatic apply_config(input logic [15:0] mi, input logic signed [31:0] sre,
                                input logic signed [31:0] sim, input logic [30:0] stre,
                                input logic [30:0] stim);
        wait_drain();
        write_reg(CFG_MAX_ITER, {16'($urandom), mi});
        write_reg(CFG_START_RE, sre);
        write_reg(CFG_START_IM, sim);
        write_reg(CFG_STEP_RE, {1'($urandom), stre});
        write_reg(CFG_STEP_IM, {1'($urandom), stim});
        cfg_we       <= 1'b0;
        cfg_max_iter = mi;
        cfg_start_re = sre;
        cfg_start_im = sim;
        cfg_step_re  = stre;
        cfg_step_im  = stim;
    endtask

    // receiver: random stall after each word, plus an optional long hold-off
    always @(posedge clk) begin
        if (hold_len > 0) begin
            hold_len  = hold_len - 1;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_stall  <= (stall_left > 0);
        end else if (out_valid && !out_stall) begin
            stall_left = no_gaps ? 0 : $urandom_range(0, 4);
            out_stall  <= (stall_left > 0);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // compare each output word with the oldest pending count
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (escape_counts_q.size() == 0) begin
                bad_words++;
                if (bad_words <= MAX_REPORTS)
                    $display("unexpected word: x=%0d y=%0d count=%0d",
                             out_word.out_x, out_word.out_y, out_word.iter_count);
            end else begin
                want = escape_counts_q.pop_front();
                if (out_word.out_x !== want.out_x || out_word.out_y !== want.out_y ||
                    out_word.iter_count !== want.iter_count) begin
                    bad_words++;
                    if (bad_words <= MAX_REPORTS)
                        $display("bad word: exp x=%0d y=%0d count=%0d, got x=%0d y=%0d count=%0d",
                                 want.out_x, want.out_y, want.iter_count,
                                 out_word.out_x, out_word.out_y, out_word.iter_count);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_count = 0;
        else if (rst_n)
            idle_count = idle_count + 1;
        if (idle_count >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // reset values, image corners
    task automatic test_reset_defaults();
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd512, 10'd300);
    endtask

    // zero iteration limit gives a zero count
    task automatic test_zero_limit();
        apply_config(16'd0, -32'sd201326592, -32'sd20000000, 31'd600000, 31'd400000);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
    endtask

    // points inside the set run to the limit
    task automatic test_bounded_points();
        apply_config(16'd1000, -32'sd134217728, 32'sd0, 31'd0, 31'd0);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        apply_config(16'd1, -32'sd134217728, 32'sd0, 31'd0, 31'd0);
        send_pixel(10'd7, 10'd9);
        // near the boundary, long but finite orbits
        apply_config(16'd1000, -32'sd201326592, 32'sd26843546, 31'd1000, 31'd1000);
        send_pixel(10'd3, 10'd5);
        send_pixel(10'd1023, 10'd1023);
    endtask

    // coordinate saturation and the largest limit
    task automatic test_coord_saturation();
        apply_config(16'hFFFF, 32'sh7FFFFFFF, 32'sh80000000, 31'h7FFFFFFF, 31'h7FFFFFFF);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd0, 10'd1);
        send_pixel(10'd1, 10'd0);
        // c = 1 escapes after a few steps
        apply_config(16'hFFFF, ONE_Q, 32'sd0, 31'd0, 31'd0);
        send_pixel(10'd512, 10'd512);
    endtask

    // writes to unused indexes must leave the registers alone
    task automatic test_unknown_index();
        wait_drain();
        for (int k = int'(CFG_STEP_IM) + 1; k < (1 << $bits(t_cfg_idx)); k++)
            write_reg(t_cfg_idx'(k), $urandom);
        cfg_we <= 1'b0;
        repeat (3) send_pixel(10'($urandom), 10'($urandom));
    endtask

    // long receiver hold-off while words keep coming
    task automatic test_backpressure();
        apply_config(16'd8, -32'sd201326592, -32'sd67108864, 31'd500000, 31'd500000);
        hold_len = 300;
        repeat (8) send_pixel(10'($urandom), 10'($urandom));
    endtask

    // random phases: windows around the set, full-range registers, deep windows
    task automatic test_random_sweep();
        int kind;
        int count;
        for (int ph = 0; ph < 12; ph++) begin
            kind    = $urandom_range(0, 3);
            count   = 48;
            no_gaps = 1'b0;
            if (kind == 2) begin
                apply_config(16'($urandom_range(1, 255)), $urandom, $urandom,
                             31'($urandom), 31'($urandom));
            end else if (kind == 3) begin
                count = 12;
                apply_config(16'($urandom_range(200, 600)),
                             -32'sd671088640 + $urandom_range(0, 536870912),
                             -32'sd335544320 + $urandom_range(0, 335544320),
                             31'($urandom_range(0, 1 << 20)), 31'($urandom_range(0, 1 << 20)));
            end else begin
                apply_config(16'($urandom_range(1, 64)),
                             -32'sd671088640 + $urandom_range(0, 536870912),
                             -32'sd335544320 + $urandom_range(0, 335544320),
                             31'($urandom_range(0, 1 << 20)), 31'($urandom_range(0, 1 << 20)));
            end
            // some phases run without any gaps on either side
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (count) send_pixel(10'($urandom), 10'($urandom));
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_zero_limit();
        test_bounded_points();
        test_coord_saturation();
        test_unknown_index();
        test_backpressure();
        test_random_sweep();
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (bad_words == 0 && escape_counts_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
